>>> src/sdc_pkg.sv
// ----------------------------------------------------------------------------
// sdc_pkg
// Shared constants, types and stencil term tables for the derivative block.
// ----------------------------------------------------------------------------
package sdc_pkg;

   localparam int SAMPLE_BITS = 32;
   localparam int FRAC_BITS   = 16;
   localparam int OUT_BITS    = 48;
   localparam int H_BITS      = 32;
   localparam int NUM_POINTS  = 25;
   localparam int CODE_BITS   = 5;
   localparam int COEF_BITS   = 6;
   localparam int NUM_BITS    = SAMPLE_BITS + 8;
   localparam int HH_BITS     = 2 * H_BITS;
   localparam int PROD_BITS   = NUM_BITS + HH_BITS;
   localparam int QUO_BITS    = PROD_BITS - FRAC_BITS;
   localparam int DIV_DIGITS  = 8;
   localparam int DIV_STEPS   = QUO_BITS / DIV_DIGITS;
   localparam int NUM_DERIV   = 9;
   localparam int NUM_TERMS   = 5;
   localparam int CSR_BITS    = 2;

   localparam logic [CSR_BITS-1:0] CSR_FOURTH_ORDER = 2'd0;
   localparam logic [CSR_BITS-1:0] CSR_INV_X        = 2'd1;
   localparam logic [CSR_BITS-1:0] CSR_INV_Y        = 2'd2;
   localparam logic [CSR_BITS-1:0] CSR_INV_Z        = 2'd3;

   localparam logic [1:0] DIV_ONE    = 2'd0;
   localparam logic [1:0] DIV_TWO    = 2'd1;
   localparam logic [1:0] DIV_FOUR   = 2'd2;
   localparam logic [1:0] DIV_TWELVE = 2'd3;

   typedef struct packed {
      logic [CODE_BITS-1:0]        point;
      logic signed [COEF_BITS-1:0] coef;
   } term_type;

   typedef struct packed {
      logic                       start;
      logic signed [NUM_BITS-1:0] num;
      logic [HH_BITS-1:0]         h;
      logic                       big_shift;
      logic [1:0]                 div_kind;
   } scale_cmd_type;

   typedef struct packed {
      logic                done;
      logic [OUT_BITS-1:0] value;
      logic                sat;
   } scale_res_type;

   function automatic term_type mk_term(input int point, input int coef);
      term_type r;
      r.point = CODE_BITS'(point);
      r.coef  = COEF_BITS'(coef);
      return r;
   endfunction

   // Stencil position and weight of term t for derivative j.
   function automatic term_type term_lookup(input logic [3:0] j, input logic order4,
                                            input logic [2:0] t);
      int a;
      int p;
      int m;
      int p2;
      int m2;
      int b;
      term_type r;
      a  = (j < 4'd3) ? int'(j) : (j < 4'd6) ? int'(j) - 3 : int'(j) - 6;
      p  = 1 + 2 * a;
      m  = 2 + 2 * a;
      p2 = 7 + 2 * a;
      m2 = 8 + 2 * a;
      b  = 13 + 4 * a;
      r  = mk_term(0, 0);
      if (j < 4'd3) begin
         if (order4) begin
            unique case (t)
               3'd0:    r = mk_term(m2, 1);
               3'd1:    r = mk_term(p2, -1);
               3'd2:    r = mk_term(p, 8);
               3'd3:    r = mk_term(m, -8);
               default: r = mk_term(0, 0);
            endcase
         end else begin
            unique case (t)
               3'd0:    r = mk_term(p, 1);
               3'd1:    r = mk_term(m, -1);
               default: r = mk_term(0, 0);
            endcase
         end
      end else if (j < 4'd6) begin
         if (order4) begin
            unique case (t)
               3'd0:    r = mk_term(m2, -1);
               3'd1:    r = mk_term(p2, -1);
               3'd2:    r = mk_term(p, 16);
               3'd3:    r = mk_term(m, 16);
               3'd4:    r = mk_term(0, -30);
               default: r = mk_term(0, 0);
            endcase
         end else begin
            unique case (t)
               3'd0:    r = mk_term(p, 1);
               3'd1:    r = mk_term(m, 1);
               3'd2:    r = mk_term(0, -2);
               default: r = mk_term(0, 0);
            endcase
         end
      end else begin
         unique case (t)
            3'd0:    r = mk_term(b, 1);
            3'd1:    r = mk_term(b + 1, -1);
            3'd2:    r = mk_term(b + 2, -1);
            3'd3:    r = mk_term(b + 3, 1);
            default: r = mk_term(0, 0);
         endcase
      end
      return r;
   endfunction

endpackage

>>> src/sdc_ram.sv
// ----------------------------------------------------------------------------
// sdc_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module sdc_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> src/sdc_scale.sv
// ----------------------------------------------------------------------------
// sdc_scale
// Multiplies a stencil sum by a spacing factor, divides, rounds and saturates.
// ----------------------------------------------------------------------------
module sdc_scale (
   input  logic                   clock,
   input  logic                   reset,
   input  sdc_pkg::scale_cmd_type cmd,
   output sdc_pkg::scale_res_type res
);
   import sdc_pkg::*;

   localparam logic [2:0] SC_IDLE  = 3'd0;
   localparam logic [2:0] SC_MUL   = 3'd1;
   localparam logic [2:0] SC_SHIFT = 3'd2;
   localparam logic [2:0] SC_DIV   = 3'd3;
   localparam logic [2:0] SC_FIN   = 3'd4;

   logic [2:0]            state_ff, state_in;
   logic [1:0]            mcnt_ff, mcnt_in;
   logic [3:0]            dcnt_ff, dcnt_in;
   logic                  neg_ff, neg_in;
   logic [NUM_BITS-1:0]   mag_ff, mag_in;
   logic [HH_BITS-1:0]    h_ff, h_in;
   logic                  big_ff, big_in;
   logic [1:0]            kind_ff, kind_in;
   logic [PROD_BITS-1:0]  x_ff, x_in;
   logic [QUO_BITS-1:0]   yq_ff, yq_in;
   logic [1:0]            rem_ff, rem_in;
   logic                  rbit_ff, rbit_in;
   logic [QUO_BITS:0]     q_ff, q_in;
   scale_res_type         res_ff, res_in;

   logic [H_BITS-1:0]     mul_a, mul_b;
   logic [HH_BITS-1:0]    pp;
   logic [6:0]            kshift;
   logic [6:0]            kbit;
   logic [1:0]            r;
   logic [2:0]            r3;
   logic [DIV_DIGITS-1:0] dig, qb;
   logic [QUO_BITS:0]     lim, qsat;
   logic                  sat;

   always_comb begin
      state_in = state_ff;
      mcnt_in  = mcnt_ff;
      dcnt_in  = dcnt_ff;
      neg_in   = neg_ff;
      mag_in   = mag_ff;
      h_in     = h_ff;
      big_in   = big_ff;
      kind_in  = kind_ff;
      x_in     = x_ff;
      yq_in    = yq_ff;
      rem_in   = rem_ff;
      rbit_in  = rbit_ff;
      q_in     = q_ff;
      res_in   = res_ff;
      res_in.done = 1'b0;

      mul_a  = mcnt_ff[1] ? H_BITS'(mag_ff[NUM_BITS-1:H_BITS]) : mag_ff[H_BITS-1:0];
      mul_b  = mcnt_ff[0] ? h_ff[HH_BITS-1:H_BITS] : h_ff[H_BITS-1:0];
      pp     = HH_BITS'(mul_a) * HH_BITS'(mul_b);

      kshift = (big_ff ? 7'd32 : 7'd16) +
               ((kind_ff == DIV_TWO) ? 7'd1 : (kind_ff == DIV_ONE) ? 7'd0 : 7'd2);
      kbit   = kshift - 7'd1;

      dig = yq_ff[QUO_BITS-1 -: DIV_DIGITS];
      r   = rem_ff;
      qb  = '0;
      for (int i = DIV_DIGITS - 1; i >= 0; i--) begin
         r3 = {r, dig[i]};
         if (r3 >= 3'd3) begin
            qb[i] = 1'b1;
            r3    = r3 - 3'd3;
         end
         r = r3[1:0];
      end

      lim  = neg_ff ? ((QUO_BITS+1)'(1) << (OUT_BITS - 1))
                    : (((QUO_BITS+1)'(1) << (OUT_BITS - 1)) - (QUO_BITS+1)'(1));
      sat  = q_ff > lim;
      qsat = sat ? lim : q_ff;

      unique case (state_ff)
         SC_IDLE: begin
            if (cmd.start) begin
               neg_in   = cmd.num[NUM_BITS-1];
               mag_in   = cmd.num[NUM_BITS-1] ? NUM_BITS'(-cmd.num) : NUM_BITS'(cmd.num);
               h_in     = cmd.h;
               big_in   = cmd.big_shift;
               kind_in  = cmd.div_kind;
               x_in     = '0;
               mcnt_in  = '0;
               state_in = SC_MUL;
            end
         end
         SC_MUL: begin
            x_in    = x_ff + (PROD_BITS'(pp) << (H_BITS * (int'(mcnt_ff[0]) + int'(mcnt_ff[1]))));
            mcnt_in = mcnt_ff + 2'd1;
            if (mcnt_ff == 2'd3) begin
               state_in = SC_SHIFT;
            end
         end
         SC_SHIFT: begin
            yq_in   = QUO_BITS'(x_ff >> kshift);
            rbit_in = x_ff[kbit];
            rem_in  = '0;
            dcnt_in = '0;
            if (kind_ff == DIV_TWELVE) begin
               state_in = SC_DIV;
            end else begin
               q_in     = (QUO_BITS+1)'(x_ff >> kshift) + (QUO_BITS+1)'(x_ff[kbit]);
               state_in = SC_FIN;
            end
         end
         SC_DIV: begin
            yq_in   = {yq_ff[QUO_BITS-DIV_DIGITS-1:0], qb};
            rem_in  = r;
            dcnt_in = dcnt_ff + 4'd1;
            if (dcnt_ff == 4'(DIV_STEPS - 1)) begin
               state_in = SC_FIN;
               q_in     = (QUO_BITS+1)'({yq_ff[QUO_BITS-DIV_DIGITS-1:0], qb}) +
                          (QUO_BITS+1)'((r == 2'd2) || ((r == 2'd1) && rbit_ff));
            end
         end
         SC_FIN: begin
            res_in.done  = 1'b1;
            res_in.sat   = sat;
            res_in.value = neg_ff ? OUT_BITS'(-qsat[OUT_BITS-1:0]) : qsat[OUT_BITS-1:0];
            state_in     = SC_IDLE;
         end
         default: begin
            state_in = SC_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= SC_IDLE;
         res_ff.done <= 1'b0;
      end else begin
         state_ff    <= state_in;
         res_ff.done <= res_in.done;
      end
      res_ff.value <= res_in.value;
      res_ff.sat   <= res_in.sat;
      mcnt_ff      <= mcnt_in;
      dcnt_ff      <= dcnt_in;
      neg_ff       <= neg_in;
      mag_ff       <= mag_in;
      h_ff         <= h_in;
      big_ff       <= big_in;
      kind_ff      <= kind_in;
      x_ff         <= x_in;
      yq_ff        <= yq_in;
      rem_ff       <= rem_in;
      rbit_ff      <= rbit_in;
      q_ff         <= q_in;
   end

   assign res = res_ff;

endmodule

>>> src/stencil_derivative_3d.sv
// ----------------------------------------------------------------------------
// stencil_derivative_3d
// Nine central finite-difference derivatives from a 25-point 3-D stencil.
// ----------------------------------------------------------------------------
// Samples are offered on req_point_code, req_sample_value and req_last_point
// with start; a transfer happens when start is high and busy is low. Each
// sample is written into a 25-entry sample RAM at its position code; codes
// above 24 store nothing. A sample without req_last_point leaves busy low. A
// sample with req_last_point starts the evaluation: for each of the nine
// derivatives the sequencer reads five RAM entries and sums their weighted
// values, forms the spacing factor on a 32x32 multiplier, and hands both to
// the scaling unit, which builds the product in four partial products,
// shifts, divides by three a byte per cycle for the first and second
// derivatives in fourth-order mode, rounds and saturates. When the last
// derivative is done, rsp_valid is high for a single cycle with the nine
// results and the saturation flag; the receiver cannot stall. Registers are
// written through csr_write at any idle time. Reset clears the control state
// and the fourth-order register and sets the three inverse-spacing registers
// to 65536; the sample RAM keeps its contents and needs no clearing pass.
module stencil_derivative_3d (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     start,
   output logic                                     busy,
   input  logic [sdc_pkg::CODE_BITS-1:0]            req_point_code,
   input  logic signed [sdc_pkg::SAMPLE_BITS-1:0]   req_sample_value,
   input  logic                                     req_last_point,
   output logic                                     rsp_valid,
   output logic signed [sdc_pkg::OUT_BITS-1:0]      rsp_d_x,
   output logic signed [sdc_pkg::OUT_BITS-1:0]      rsp_d_y,
   output logic signed [sdc_pkg::OUT_BITS-1:0]      rsp_d_z,
   output logic signed [sdc_pkg::OUT_BITS-1:0]      rsp_d_xx,
   output logic signed [sdc_pkg::OUT_BITS-1:0]      rsp_d_yy,
   output logic signed [sdc_pkg::OUT_BITS-1:0]      rsp_d_zz,
   output logic signed [sdc_pkg::OUT_BITS-1:0]      rsp_d_xy,
   output logic signed [sdc_pkg::OUT_BITS-1:0]      rsp_d_xz,
   output logic signed [sdc_pkg::OUT_BITS-1:0]      rsp_d_yz,
   output logic                                     rsp_saturated,
   input  logic                                     csr_write,
   input  logic [sdc_pkg::CSR_BITS-1:0]             csr_index,
   input  logic [sdc_pkg::H_BITS-1:0]               csr_data
);
   import sdc_pkg::*;

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_GATHER = 3'd1;
   localparam logic [2:0] ST_HMUL   = 3'd2;
   localparam logic [2:0] ST_SCALE  = 3'd3;
   localparam logic [2:0] ST_WAIT   = 3'd4;

   logic [2:0]                  state_ff, state_in;
   logic [3:0]                  j_ff, j_in;
   logic [2:0]                  t_ff, t_in;
   logic signed [COEF_BITS-1:0] coef_ff, coef_in;
   logic signed [NUM_BITS-1:0]  num_ff, num_in;
   logic [HH_BITS-1:0]          h_ff, h_in;
   logic                        sat_ff, sat_in;
   logic                        valid_ff, valid_in;
   logic [OUT_BITS-1:0]         out_ff [NUM_DERIV];
   logic                        order_ff;
   logic [H_BITS-1:0]           inv_x_ff, inv_y_ff, inv_z_ff;

   logic                        accept;
   logic                        ram_we;
   logic [CODE_BITS-1:0]        rd_addr;
   logic [SAMPLE_BITS-1:0]      rd_data;
   term_type                    term_now;
   logic signed [NUM_BITS-1:0]  samp_ext, coef_ext, prod;
   logic [H_BITS-1:0]           ha, hb;
   scale_cmd_type               cmd;
   scale_res_type               res;

   assign busy   = (state_ff != ST_IDLE);
   assign accept = start && !busy;
   assign ram_we = accept && (req_point_code < CODE_BITS'(NUM_POINTS));

   sdc_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(NUM_POINTS)) u_samples (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (req_point_code),
      .wr_data (req_sample_value),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   sdc_scale u_scale (
      .clock (clock),
      .reset (reset),
      .cmd   (cmd),
      .res   (res)
   );

   always_comb begin
      term_now = term_lookup(j_ff, order_ff, t_ff);
      rd_addr  = (state_ff == ST_GATHER) ? term_now.point : '0;
      samp_ext = NUM_BITS'($signed(rd_data));
      coef_ext = NUM_BITS'(coef_ff);
      prod     = samp_ext * coef_ext;

      unique case (j_ff)
         4'd0, 4'd3: begin ha = inv_x_ff; hb = inv_x_ff; end
         4'd1, 4'd4: begin ha = inv_y_ff; hb = inv_y_ff; end
         4'd2, 4'd5: begin ha = inv_z_ff; hb = inv_z_ff; end
         4'd6:       begin ha = inv_x_ff; hb = inv_y_ff; end
         4'd7:       begin ha = inv_x_ff; hb = inv_z_ff; end
         default:    begin ha = inv_y_ff; hb = inv_z_ff; end
      endcase

      cmd.start     = (state_ff == ST_SCALE);
      cmd.num       = num_ff;
      cmd.h         = h_ff;
      cmd.big_shift = (j_ff >= 4'd3);
      if (j_ff < 4'd3) begin
         cmd.div_kind = order_ff ? DIV_TWELVE : DIV_TWO;
      end else if (j_ff < 4'd6) begin
         cmd.div_kind = order_ff ? DIV_TWELVE : DIV_ONE;
      end else begin
         cmd.div_kind = DIV_FOUR;
      end
   end

   always_comb begin
      state_in = state_ff;
      j_in     = j_ff;
      t_in     = t_ff;
      coef_in  = coef_ff;
      num_in   = num_ff;
      h_in     = h_ff;
      sat_in   = sat_ff;
      valid_in = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept && req_last_point) begin
               j_in     = '0;
               t_in     = '0;
               num_in   = '0;
               sat_in   = 1'b0;
               state_in = ST_GATHER;
            end
         end
         ST_GATHER: begin
            coef_in = term_now.coef;
            if (t_ff != 3'd0) begin
               num_in = num_ff + prod;
            end
            t_in = t_ff + 3'd1;
            if (t_ff == 3'(NUM_TERMS)) begin
               state_in = ST_HMUL;
            end
         end
         ST_HMUL: begin
            h_in     = (j_ff < 4'd3) ? HH_BITS'(ha) : HH_BITS'(ha) * HH_BITS'(hb);
            state_in = ST_SCALE;
         end
         ST_SCALE: begin
            state_in = ST_WAIT;
         end
         ST_WAIT: begin
            if (res.done) begin
               sat_in = sat_ff | res.sat;
               if (j_ff == 4'(NUM_DERIV - 1)) begin
                  valid_in = 1'b1;
                  state_in = ST_IDLE;
               end else begin
                  j_in     = j_ff + 4'd1;
                  t_in     = '0;
                  num_in   = '0;
                  state_in = ST_GATHER;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         valid_ff <= 1'b0;
         order_ff <= 1'b0;
         inv_x_ff <= H_BITS'(65536);
         inv_y_ff <= H_BITS'(65536);
         inv_z_ff <= H_BITS'(65536);
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
         if (csr_write) begin
            unique case (csr_index)
               CSR_FOURTH_ORDER: order_ff <= csr_data[0];
               CSR_INV_X:        inv_x_ff <= csr_data;
               CSR_INV_Y:        inv_y_ff <= csr_data;
               CSR_INV_Z:        inv_z_ff <= csr_data;
               default:          order_ff <= order_ff;
            endcase
         end
      end
      j_ff    <= j_in;
      t_ff    <= t_in;
      coef_ff <= coef_in;
      num_ff  <= num_in;
      h_ff    <= h_in;
      sat_ff  <= sat_in;
      if ((state_ff == ST_WAIT) && res.done) begin
         out_ff[j_ff] <= res.value;
      end
   end

   assign rsp_valid     = valid_ff;
   assign rsp_d_x       = out_ff[0];
   assign rsp_d_y       = out_ff[1];
   assign rsp_d_z       = out_ff[2];
   assign rsp_d_xx      = out_ff[3];
   assign rsp_d_yy      = out_ff[4];
   assign rsp_d_zz      = out_ff[5];
   assign rsp_d_xy      = out_ff[6];
   assign rsp_d_xz      = out_ff[7];
   assign rsp_d_yz      = out_ff[8];
   assign rsp_saturated = sat_ff;

endmodule
